@@ design/spq_pkg.sv @@
// Package for the stable priority queue.
// Holds the capacity default, the function and status codes, and the cell types.
// No dependencies.
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_PROC = 1'b1;

    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_PROCESSED = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [7:0]  pri;
        logic [31:0] id;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic   add;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

@@ design/spq_cell.sv @@
// One storage cell of the sorted queue chain.
// Depends on spq_pkg for the entry and control types.
// Shifts right on insert behind it, shifts left on pop.
module spq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_after,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_after
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // this cell lies at or behind the insert position
    assign o_after = ~r_entry.valid | (r_entry.pri > i_ctl.new_entry.pri);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_right;
        end else if (i_ctl.add && o_after) begin
            if (i_left_after) begin
                n_entry = i_left;
            end else begin
                n_entry = i_ctl.new_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.pri     <= n_entry.pri;
        r_entry.id      <= n_entry.id;
        r_entry.payload <= n_entry.payload;
    end

    assign o_entry = r_entry;

endmodule

@@ design/stable_priority_queue.sv @@
// Stable priority queue of tasks: sorted chain of cells plus output register.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   i_func = add (store i_priority_req and i_payload_tag under the next id)
//   or process (remove the head task, smallest priority, oldest first).
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   command: status, task id, priority, payload and occupancy after it.
// Result: registered, and presented in the cycle after the input transfer.
// Throughput: one command per cycle when not stalled; every cell compares and
//   shifts in parallel, and the output register decouples the two channels.
// Stall: while a result waits under i_out_stall, o_in_stall is high and the
//   held result does not change; input transfers resume as it is taken.
// Reset: synchronous, active low; the queue empties, the next id is 1 and
//   the output register holds no result.
// An add to a full queue returns status full and uses no id; a process on
//   an empty queue returns status empty. Both carry zero task fields.
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_priority_req,
    input  logic [31:0] i_payload_tag,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_task_id,
    output logic [7:0]  o_task_priority,
    output logic [31:0] o_task_payload,
    output logic [4:0]  o_occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_entry    w_entry [CAPACITY];
    logic      w_after [CAPACITY];
    t_cell_ctl w_ctl;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_task_id;
    logic [7:0]  r_task_priority;
    logic [31:0] r_task_payload;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [31:0] r_next_id;

    logic        w_fire;
    logic        w_full;
    logic        w_empty;
    logic [1:0]  w_status;
    t_entry      w_result;
    logic [CW+4:0] w_count_ext;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_fire     = i_in_valid & ~o_in_stall;
    assign w_full     = w_entry[CAPACITY-1].valid;
    assign w_empty    = ~w_entry[0].valid;

    always_comb begin
        w_ctl.add               = w_fire && (i_func == FUNC_ADD) && !w_full;
        w_ctl.pop               = w_fire && (i_func == FUNC_PROC) && !w_empty;
        w_ctl.new_entry.valid   = 1'b1;
        w_ctl.new_entry.pri     = i_priority_req;
        w_ctl.new_entry.id      = r_next_id;
        w_ctl.new_entry.payload = i_payload_tag;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left;
            logic   w_left_after;
            t_entry w_right;
            if (g == 0) begin : g_head
                assign w_left       = w_ctl.new_entry;
                assign w_left_after = 1'b0;
            end else begin : g_mid
                assign w_left       = w_entry[g-1];
                assign w_left_after = w_after[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_entry[g+1];
            end
            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_left       (w_left),
                .i_left_after (w_left_after),
                .i_right      (w_right),
                .o_entry      (w_entry[g]),
                .o_after      (w_after[g])
            );
        end
    endgenerate

    always_comb begin
        w_result = '0;
        n_count  = r_count;
        if (i_func == FUNC_ADD) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_ADDED;
                w_result = w_ctl.new_entry;
                n_count  = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                w_status = ST_PROCESSED;
                w_result = w_entry[0];
                n_count  = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_next_id   <= 32'd1;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_ctl.add) begin
                r_next_id <= r_next_id + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status        <= w_status;
            r_task_id       <= w_result.id;
            r_task_priority <= w_result.pri;
            r_task_payload  <= w_result.payload;
        end
    end

    assign w_count_ext     = {5'd0, r_count};
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_task_id       = r_task_id;
    assign o_task_priority = r_task_priority;
    assign o_task_payload  = r_task_payload;
    assign o_occupancy     = w_count_ext[4:0];

    a_count_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == w_empty)
        else $error("count and head cell disagree");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_func == FUNC_ADD && w_full) |=>
        (r_count == $past(r_count) && r_next_id == $past(r_next_id)))
        else $error("refused add changed the queue");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not shrink the queue");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> (o_occupancy == 5'd0))
        else $error("empty result with nonzero occupancy");

endmodule
